### sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is high
`define QDBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds across reset
`define QDBS_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/qdbs_pkg.sv
// types, character codes and byte classifiers for the delimiter balance scanner
// no dependencies
package qdbs_pkg;

   localparam int CNT10_W = 10;
   localparam int CNT16_W = 16;
   localparam logic [CNT10_W-1:0] CNT10_MAX = '1;

   localparam logic [7:0] CH_PIPE    = 8'h7C;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_LSQUARE = 8'h5B;
   localparam logic [7:0] CH_RSQUARE = 8'h5D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   typedef enum logic [1:0] {
      BR_NONE,
      BR_PAREN,
      BR_BRACE,
      BR_SQUARE
   } bracket_type;

   typedef struct packed {
      logic               mismatch;
      logic               in_single;
      logic               in_double;
      logic               esc_pending;
      logic [CNT10_W-1:0] peak;
      logic [CNT10_W-1:0] operators;
      logic [CNT10_W-1:0] escapes;
      logic [CNT10_W-1:0] symbols;
      logic [CNT10_W-1:0] alnums;
      logic [CNT16_W-1:0] digits;
      logic [CNT16_W-1:0] length;
   } scan_state_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      logic hit;
      case (c) inside
         CH_PIPE, CH_AMP, CH_SEMI, CH_DOLLAR, CH_LT, CH_GT: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic bracket_type open_code(input logic [7:0] c);
      bracket_type code;
      unique case (c)
         CH_LPAREN:  code = BR_PAREN;
         CH_LBRACE:  code = BR_BRACE;
         CH_LSQUARE: code = BR_SQUARE;
         default:    code = BR_NONE;
      endcase
      return code;
   endfunction

   function automatic bracket_type close_code(input logic [7:0] c);
      bracket_type code;
      unique case (c)
         CH_RPAREN:  code = BR_PAREN;
         CH_RBRACE:  code = BR_BRACE;
         CH_RSQUARE: code = BR_SQUARE;
         default:    code = BR_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [CNT10_W-1:0] sat_inc10(input logic [CNT10_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [CNT16_W-1:0] sat_inc16(input logic [CNT16_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

endpackage

### sv/quoted_delimiter_balance_scanner.sv
// channel | dir | beat contents                        | accepted when
// req_    | in  | byte_in, last_byte                   | req_valid & req_ready
// rsp_    | out | unbalanced, nesting and byte metrics | rsp_valid & rsp_ready
//
// one byte per cycle, back to back while req_ready is high; set by the bracket
// stack memory, which is read at the new top each cycle and written on a push,
// with a bypass register for a push read back in the next cycle
// a result is shown from an output register in the cycle after its last byte is accepted
// req_ready drops only for a last byte while an earlier result is still held
// reset clears the scan state and the result valid flag; the stack memory needs no clearing
// depends on qdbs_pkg
module quoted_delimiter_balance_scanner #(
   parameter int SCAN_LIMIT  = 1024,
   parameter int STACK_DEPTH = 1022
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_byte_in,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_unbalanced,
   output logic [qdbs_pkg::CNT10_W-1:0]  rsp_max_nesting,
   output logic [qdbs_pkg::CNT10_W-1:0]  rsp_operator_total,
   output logic [qdbs_pkg::CNT10_W-1:0]  rsp_escape_total,
   output logic [qdbs_pkg::CNT10_W-1:0]  rsp_symbol_total,
   output logic [qdbs_pkg::CNT10_W-1:0]  rsp_alnum_total,
   output logic [qdbs_pkg::CNT16_W-1:0]  rsp_digit_total,
   output logic [qdbs_pkg::CNT16_W-1:0]  rsp_string_length
);
   import qdbs_pkg::*;

   localparam int StackEntries = STACK_DEPTH + 1;
   localparam int AddrW        = $clog2(StackEntries);
   localparam int CountW       = $clog2(StackEntries + 1);
   localparam int CmpW         = (CountW > CNT10_W) ? CountW : CNT10_W;
   localparam logic [CountW-1:0]  CountFull = CountW'(StackEntries);
   localparam logic [CNT16_W:0]   ScanEnd   = (CNT16_W + 1)'(SCAN_LIMIT - 1);

   bracket_type    stack_mem [StackEntries];

   scan_state_type st_ff, st_nx, st_in;
   logic [CountW-1:0] count_ff, count_nx, count_in;
   bracket_type    rd_data_ff, fwd_code_ff, fwd_code_in, top_code;
   logic           fwd_ff, fwd_in;
   logic [AddrW-1:0] rd_addr, wr_addr;
   logic           push;
   logic           accept, clear, scan;
   logic [CmpW-1:0] depth_ext;
   logic [CNT10_W-1:0] depth_cap;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           unbal_ff;
   scan_state_type rsp_st_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready || !req_last_byte;
   assign accept    = req_valid && req_ready;
   assign clear     = accept && req_last_byte;
   assign scan      = {1'b0, st_ff.length} < ScanEnd;
   assign top_code  = fwd_ff ? fwd_code_ff : rd_data_ff;
   assign wr_addr   = count_ff[AddrW-1:0];
   assign depth_ext = CmpW'(count_ff + 1'b1);
   assign depth_cap = (depth_ext > CmpW'(CNT10_MAX)) ? CNT10_MAX : depth_ext[CNT10_W-1:0];

   always_comb begin
      st_nx    = st_ff;
      count_nx = count_ff;
      push     = 1'b0;
      if (accept) begin
         if (scan) begin
            if (is_alnum(req_byte_in)) begin
               st_nx.alnums = sat_inc10(st_ff.alnums);
            end else if (!is_space(req_byte_in)) begin
               st_nx.symbols = sat_inc10(st_ff.symbols);
            end
            if (!st_ff.esc_pending && (req_byte_in == CH_BSLASH)) begin
               st_nx.escapes     = sat_inc10(st_ff.escapes);
               st_nx.esc_pending = 1'b1;
            end else begin
               if (!st_ff.in_double && (req_byte_in == CH_SQUOTE) && !st_ff.esc_pending) begin
                  st_nx.in_single = !st_ff.in_single;
               end else if (!st_ff.in_single && (req_byte_in == CH_DQUOTE) &&
                            !st_ff.esc_pending) begin
                  st_nx.in_double = !st_ff.in_double;
               end
               if (!st_nx.in_single && !st_nx.in_double) begin
                  if (is_operator(req_byte_in)) begin
                     st_nx.operators = sat_inc10(st_ff.operators);
                  end
                  if (open_code(req_byte_in) != BR_NONE) begin
                     if (count_ff != CountFull) begin
                        push     = 1'b1;
                        count_nx = count_ff + 1'b1;
                        if (depth_cap > st_ff.peak) begin
                           st_nx.peak = depth_cap;
                        end
                     end else begin
                        st_nx.mismatch = 1'b1;
                     end
                  end else if (close_code(req_byte_in) != BR_NONE) begin
                     if ((count_ff == '0) || (top_code != close_code(req_byte_in))) begin
                        st_nx.mismatch = 1'b1;
                     end else begin
                        count_nx = count_ff - 1'b1;
                     end
                  end
               end
               st_nx.esc_pending = 1'b0;
            end
         end
         if (is_digit(req_byte_in)) begin
            st_nx.digits = sat_inc16(st_ff.digits);
         end
         st_nx.length = sat_inc16(st_ff.length);
      end
   end

   // last beat returns the scan state to its reset value
   assign st_in    = clear ? '0 : st_nx;
   assign count_in = clear ? '0 : count_nx;

   // read the entry that becomes the top after this beat
   assign rd_addr     = (count_in == '0) ? '0 : AddrW'(count_in - 1'b1);
   assign fwd_in      = push && (wr_addr == rd_addr);
   assign fwd_code_in = open_code(req_byte_in);

   assign rsp_valid_in = clear || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[wr_addr] <= fwd_code_in;
      end
      rd_data_ff  <= stack_mem[rd_addr];
      fwd_code_ff <= fwd_code_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= '0;
         count_ff     <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         count_ff     <= count_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         rsp_st_ff <= st_nx;
         unbal_ff  <= st_nx.mismatch || (count_nx != '0) || st_nx.in_single ||
                      st_nx.in_double;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_unbalanced     = unbal_ff;
   assign rsp_max_nesting    = rsp_st_ff.peak;
   assign rsp_operator_total = rsp_st_ff.operators;
   assign rsp_escape_total   = rsp_st_ff.escapes;
   assign rsp_symbol_total   = rsp_st_ff.symbols;
   assign rsp_alnum_total    = rsp_st_ff.alnums;
   assign rsp_digit_total    = rsp_st_ff.digits;
   assign rsp_string_length  = rsp_st_ff.length;

endmodule

### sv/qdbs_checker.sv
// port-level checks for the delimiter balance scanner, bound to the scanner module
// depends on qdbs_pkg and assert_macros.svh
`include "assert_macros.svh"

module qdbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [7:0]                    req_byte_in,
   input logic                          req_last_byte,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_unbalanced,
   input logic [qdbs_pkg::CNT10_W-1:0]  rsp_max_nesting,
   input logic [qdbs_pkg::CNT10_W-1:0]  rsp_operator_total,
   input logic [qdbs_pkg::CNT10_W-1:0]  rsp_escape_total,
   input logic [qdbs_pkg::CNT10_W-1:0]  rsp_symbol_total,
   input logic [qdbs_pkg::CNT10_W-1:0]  rsp_alnum_total,
   input logic [qdbs_pkg::CNT16_W-1:0]  rsp_digit_total,
   input logic [qdbs_pkg::CNT16_W-1:0]  rsp_string_length
);
   import qdbs_pkg::*;

   logic               last_beat;
   logic [CNT16_W:0]   scanned_sum;
   logic [CNT16_W:0]   length_ext;

   assign last_beat   = req_valid && req_ready && req_last_byte;
   assign scanned_sum = (CNT16_W + 1)'(rsp_alnum_total) + (CNT16_W + 1)'(rsp_symbol_total);
   assign length_ext  = (CNT16_W + 1)'(rsp_string_length);

   `QDBS_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid, "result valid after reset")
   `QDBS_ASSERT(a_last_gives_rsp, last_beat |=> rsp_valid, "no result after last beat")
   `QDBS_ASSERT(a_rsp_from_last, $rose(rsp_valid) |-> $past(last_beat),
      "result without last beat")
   `QDBS_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_string_length),
      "stalled result changed")
   `QDBS_ASSERT(a_counts_fit, rsp_valid |-> (rsp_string_length != '0) &&
      (scanned_sum <= length_ext) && (rsp_digit_total <= rsp_string_length),
      "class counts exceed length")

endmodule

bind quoted_delimiter_balance_scanner qdbs_checker u_qdbs_checker (.*);

### bench/tb_top.sv
// self-checking bench for quoted_delimiter_balance_scanner: directed and random strings,
// each result checked against an in-bench scan tracker
// depends on qdbs_pkg and quoted_delimiter_balance_scanner
`timescale 1ns / 1ps

module tb_top;
   import qdbs_pkg::*;

   localparam int SCAN_LIMIT  = 1024;
   localparam int STACK_DEPTH = 1022;

   typedef struct packed {
      logic               unbalanced;
      logic [CNT10_W-1:0] max_nesting;
      logic [CNT10_W-1:0] operator_total;
      logic [CNT10_W-1:0] escape_total;
      logic [CNT10_W-1:0] symbol_total;
      logic [CNT10_W-1:0] alnum_total;
      logic [CNT16_W-1:0] digit_total;
      logic [CNT16_W-1:0] string_length;
   } scan_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_byte_in = 8'h41;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_unbalanced;
   logic [CNT10_W-1:0] rsp_max_nesting;
   logic [CNT10_W-1:0] rsp_operator_total;
   logic [CNT10_W-1:0] rsp_escape_total;
   logic [CNT10_W-1:0] rsp_symbol_total;
   logic [CNT10_W-1:0] rsp_alnum_total;
   logic [CNT16_W-1:0] rsp_digit_total;
   logic [CNT16_W-1:0] rsp_string_length;

   // scan tracker state
   bracket_type bracket_mem [STACK_DEPTH+1];
   int   depth, peak, n_ops, n_esc, n_sym, n_alnum, n_digit, n_len;
   logic bad, in_sq, in_dq, esc;

   scan_report_type pending_reports[$];
   logic [7:0]   text[$];
   int           idle_pct = 26;
   int           fail_count = 0;

   quoted_delimiter_balance_scanner #(
      .SCAN_LIMIT  (SCAN_LIMIT),
      .STACK_DEPTH (STACK_DEPTH)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_in        (req_byte_in),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_unbalanced     (rsp_unbalanced),
      .rsp_max_nesting    (rsp_max_nesting),
      .rsp_operator_total (rsp_operator_total),
      .rsp_escape_total   (rsp_escape_total),
      .rsp_symbol_total   (rsp_symbol_total),
      .rsp_alnum_total    (rsp_alnum_total),
      .rsp_digit_total    (rsp_digit_total),
      .rsp_string_length  (rsp_string_length)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   function automatic int clamp(input int v, input int top);
      return (v > top) ? top : v;
   endfunction

   task automatic clear_scan();
      depth = 0;
      peak = 0;
      n_ops = 0;
      n_esc = 0;
      n_sym = 0;
      n_alnum = 0;
      n_digit = 0;
      n_len = 0;
      bad = 1'b0;
      in_sq = 1'b0;
      in_dq = 1'b0;
      esc = 1'b0;
   endtask

   task automatic track_scan_byte(input logic [7:0] c, input logic last);
      bracket_type opener;
      bracket_type closer;
      scan_report_type rep;
      logic is_num;
      is_num = (c >= "0" && c <= "9");
      if (n_len < SCAN_LIMIT - 1) begin
         if (is_num || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
            n_alnum++;
         else if (!(c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)))
            n_sym++;
         if (!esc && c == CH_BSLASH) begin
            n_esc++;
            esc = 1'b1;
         end else begin
            if (!in_dq && c == CH_SQUOTE && !esc)
               in_sq = !in_sq;
            else if (!in_sq && c == CH_DQUOTE && !esc)
               in_dq = !in_dq;
            if (!in_sq && !in_dq) begin
               opener = BR_NONE;
               closer = BR_NONE;
               case (c)
                  CH_PIPE, CH_AMP, CH_SEMI, CH_DOLLAR, CH_LT, CH_GT: n_ops++;
                  CH_LPAREN:  opener = BR_PAREN;
                  CH_LBRACE:  opener = BR_BRACE;
                  CH_LSQUARE: opener = BR_SQUARE;
                  CH_RPAREN:  closer = BR_PAREN;
                  CH_RBRACE:  closer = BR_BRACE;
                  CH_RSQUARE: closer = BR_SQUARE;
                  default: ;
               endcase
               if (opener != BR_NONE) begin
                  if (depth <= STACK_DEPTH) begin
                     bracket_mem[depth] = opener;
                     depth++;
                     if (depth > peak) peak = depth;
                  end else begin
                     bad = 1'b1;
                  end
               end else if (closer != BR_NONE) begin
                  if (depth == 0 || bracket_mem[depth-1] != closer) bad = 1'b1;
                  else depth--;
               end
            end
            esc = 1'b0;
         end
      end
      if (is_num) n_digit++;
      n_len++;
      if (last) begin
         rep.unbalanced     = bad || depth != 0 || in_sq || in_dq;
         rep.max_nesting    = CNT10_W'(clamp(peak, 1023));
         rep.operator_total = CNT10_W'(clamp(n_ops, 1023));
         rep.escape_total   = CNT10_W'(clamp(n_esc, 1023));
         rep.symbol_total   = CNT10_W'(clamp(n_sym, 1023));
         rep.alnum_total    = CNT10_W'(clamp(n_alnum, 1023));
         rep.digit_total    = CNT16_W'(clamp(n_digit, 65535));
         rep.string_length  = CNT16_W'(clamp(n_len, 65535));
         pending_reports.push_back(rep);
         clear_scan();
      end
   endtask

   // one beat; the tracker is updated at the accepting edge
   task automatic send_beat(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= c;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_scan_byte(c, last);
   endtask

   task automatic send_text();
      for (int i = 0; i < text.size(); i++)
         send_beat(text[i], i == text.size() - 1);
   endtask

   task automatic send_str(input string s);
      text.delete();
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      send_text();
   endtask

   task automatic send_run(input logic [7:0] c, input int count);
      text.delete();
      repeat (count) text.push_back(c);
      send_text();
   endtask

   task automatic drain_pause();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      if ($urandom_range(1)) begin
         case ($urandom_range(15))
            0:  c = CH_PIPE;
            1:  c = CH_AMP;
            2:  c = CH_SEMI;
            3:  c = CH_DOLLAR;
            4:  c = CH_LT;
            5:  c = CH_GT;
            6:  c = CH_BSLASH;
            7:  c = CH_SQUOTE;
            8:  c = CH_DQUOTE;
            9:  c = CH_LPAREN;
            10: c = CH_RPAREN;
            11: c = CH_LBRACE;
            12: c = CH_RBRACE;
            13: c = CH_LSQUARE;
            14: c = CH_RSQUARE;
            default: c = CH_SPACE;
         endcase
      end
      return c;
   endfunction

   // content that keeps a well-formed string well formed
   function automatic logic [7:0] free_byte(input logic quoted, input logic [7:0] quote_char);
      logic [7:0] c;
      do begin
         c = pick_byte();
      end while (c == CH_BSLASH || (quoted ? c == quote_char :
         (c inside {CH_SQUOTE, CH_DQUOTE, CH_LPAREN, CH_RPAREN, CH_LBRACE,
                    CH_RBRACE, CH_LSQUARE, CH_RSQUARE})));
      return c;
   endfunction

   function automatic logic [7:0] bracket_char(input bracket_type kind, input logic closing);
      case (kind)
         BR_PAREN:  return closing ? CH_RPAREN : CH_LPAREN;
         BR_BRACE:  return closing ? CH_RBRACE : CH_LBRACE;
         BR_SQUARE: return closing ? CH_RSQUARE : CH_LSQUARE;
         default:   return CH_SPACE;
      endcase
   endfunction

   task automatic build_random_text(input int max_len);
      bracket_type open_kinds[$];
      bracket_type kind;
      logic [7:0] quote_char;
      int len;
      text.delete();
      len = $urandom_range(1, max_len);
      if ($urandom_range(99) < 25) begin
         repeat (len) text.push_back(pick_byte());
      end else begin
         while (text.size() < len) begin
            case ($urandom_range(5))
               0: begin
                  kind = bracket_type'($urandom_range(1, 3));
                  open_kinds.push_back(kind);
                  text.push_back(bracket_char(kind, 1'b0));
               end
               1: begin
                  if (open_kinds.size() != 0)
                     text.push_back(bracket_char(open_kinds.pop_back(), 1'b1));
                  else
                     text.push_back(free_byte(1'b0, CH_SPACE));
               end
               2: begin
                  quote_char = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                  text.push_back(quote_char);
                  repeat ($urandom_range(4)) text.push_back(free_byte(1'b1, quote_char));
                  text.push_back(quote_char);
               end
               3: begin
                  text.push_back(CH_BSLASH);
                  text.push_back(pick_byte());
               end
               default: text.push_back(free_byte(1'b0, CH_SPACE));
            endcase
         end
         if ($urandom_range(9) != 0)
            while (open_kinds.size() != 0)
               text.push_back(bracket_char(open_kinds.pop_back(), 1'b1));
      end
   endtask

   task automatic test_directed_cases();
      send_str("([{}])");
      send_str(")");
      send_str("(]");
      send_str("'\"'");
      send_str("\"$'\\\"");
      send_str("\\\\&\\(");
      send_str("a\\'b");
      text = '{8'h01, 8'h09, 8'h0D, CH_SPACE, "0", "9", "A", "z", 8'h7F, 8'hFF};
      send_text();
   endtask

   // one string that runs past the scan window
   task automatic test_counter_ceilings();
      text.delete();
      for (int i = 0; i < 1030; i++) begin
         case (i % 4)
            0:       text.push_back(CH_DOLLAR);
            1:       text.push_back("a");
            2:       text.push_back("7");
            default: text.push_back(CH_BSLASH);
         endcase
      end
      send_text();
   endtask

   task automatic test_deep_nesting();
      send_run(CH_LPAREN, 60);
      text.delete();
      repeat (150) text.push_back(CH_LBRACE);
      repeat (150) text.push_back(CH_RBRACE);
      send_text();
   endtask

   task automatic test_random_strings();
      int sent;
      logic paused;
      sent = 0;
      paused = 1'b0;
      while (sent < 320) begin
         idle_pct = (sent >= 80 && sent < 240) ? 0 : 26;
         build_random_text(($urandom_range(9) == 0) ? 200 : 24);
         send_text();
         sent += text.size();
         if (!paused && sent >= 260) begin
            drain_pause();
            paused = 1'b1;
         end
      end
      idle_pct = 26;
   endtask

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin : report_check
      scan_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t result beat with no string outstanding", $realtime);
         end else begin
            want = pending_reports.pop_front();
            compare_field("unbalanced", want.unbalanced, rsp_unbalanced);
            compare_field("max_nesting", want.max_nesting, rsp_max_nesting);
            compare_field("operator_total", want.operator_total, rsp_operator_total);
            compare_field("escape_total", want.escape_total, rsp_escape_total);
            compare_field("symbol_total", want.symbol_total, rsp_symbol_total);
            compare_field("alnum_total", want.alnum_total, rsp_alnum_total);
            compare_field("digit_total", want.digit_total, rsp_digit_total);
            compare_field("string_length", want.string_length, rsp_string_length);
         end
      end
   end

   initial begin
      clear_scan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_counter_ceilings();
      test_deep_nesting();
      test_random_strings();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_reports.size() != 0) begin
         fail_count += pending_reports.size();
         $display("%0d results never arrived", pending_reports.size());
      end
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
